>>> rtl/core/circular_deque_buffer_defines.svh
// ----------------------------------------------------------------------------
// Circular deque buffer assertion macros
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_BUFFER_DEFINES_SVH
`define CIRCULAR_DEQUE_BUFFER_DEFINES_SVH
`ifndef SYNTHESIS
`define CDB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CDB_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CDB_ASSERT(label, clk, rst_n, prop, msg)
`define CDB_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/core/cdb_pkg.sv
// ----------------------------------------------------------------------------
// Circular deque buffer package
// Request and response items, request codes and status codes.
// ----------------------------------------------------------------------------
package cdb_pkg;

  localparam int unsigned ReqTypeW  = 3;
  localparam int unsigned IndexW    = 8;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned FillW     = 9;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_READ       = 3'd4,
    REQ_WRITE      = 3'd5,
    REQ_CLEAR      = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [ReqTypeW-1:0] req_type;
    logic [IndexW-1:0]   elem_index;
    logic [ValueW-1:0]   write_value;
  } req_t;

  typedef struct packed {
    logic [ValueW-1:0] read_value;
    status_e           status;
    logic [FillW-1:0]  fill_count;
    logic              is_empty;
    logic              is_full;
  } rsp_t;

endpackage

>>> rtl/core/circular_deque_buffer.sv
// ----------------------------------------------------------------------------
// Circular deque buffer
// Fixed-capacity double-ended ring buffer on one synchronous memory,
// tracked by a head pointer and an element count.
// ----------------------------------------------------------------------------
//  channel  | ports                                 | payload
//  ---------+---------------------------------------+--------------------
//  request  | in_valid_i, in_ready_o, in_item_i     | cdb_pkg::req_t
//  response | out_valid_o, out_ready_i, out_item_o  | cdb_pkg::rsp_t
//
//  An item does its memory access in the accept cycle; the registered read
//  data then moves into the output register once that is free.
//  The memory has a single port; a pending item blocks the next.
//  Reset clears head and count; memory contents stay undefined.
//  A stalled output holds the pending item; requests wait until it leaves.
// ----------------------------------------------------------------------------
`include "circular_deque_buffer_defines.svh"

module circular_deque_buffer #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cdb_pkg::req_t  in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cdb_pkg::rsp_t  out_item_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = CW + cdb_pkg::IndexW;
  localparam int unsigned SW = CW + 1;
  localparam int unsigned DW = (ELEM_WIDTH < cdb_pkg::ValueW) ? ELEM_WIDTH
                                                              : cdb_pkg::ValueW;

  logic [DW-1:0] mem [CAPACITY];
  logic [DW-1:0] rdata_q;

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic            pend_q;
  logic            pend_rd_q;
  cdb_pkg::status_e pend_st_q;
  logic [CW-1:0]   pend_cnt_q;

  logic          out_valid_q;
  cdb_pkg::rsp_t out_q;

  logic             accept;
  logic             out_load;
  logic             full, empty, in_range;
  logic [AW-1:0]    head_dec, head_inc;
  logic [CW-1:0]    offset;
  logic [SW-1:0]    sum;
  logic [AW-1:0]    slot;
  logic [AW-1:0]    mem_addr;
  logic             mem_we, mem_re;
  cdb_pkg::status_e st;

  assign accept   = in_valid_i && in_ready_o;
  assign out_load = pend_q && (!out_valid_q || out_ready_i);

  assign full     = cnt_q == CW'(CAPACITY);
  assign empty    = cnt_q == '0;
  assign in_range = IW'(in_item_i.elem_index) < IW'(cnt_q);

  assign head_dec = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
  assign head_inc = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);

  always_comb begin
    unique case (in_item_i.req_type)
      cdb_pkg::REQ_PUSH_BACK: offset = cnt_q;
      cdb_pkg::REQ_POP_BACK:  offset = cnt_q - CW'(1);
      default:                offset = CW'(in_item_i.elem_index);
    endcase
    sum  = SW'(head_q) + SW'(offset);
    slot = (sum >= SW'(CAPACITY)) ? AW'(sum - SW'(CAPACITY)) : AW'(sum);
  end

  always_comb begin
    head_d   = head_q;
    cnt_d    = cnt_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = slot;
    st       = cdb_pkg::ST_OK;
    unique case (in_item_i.req_type)
      cdb_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          st = cdb_pkg::ST_FULL;
        end else begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + CW'(1);
        end
      end
      cdb_pkg::REQ_PUSH_FRONT: begin
        mem_addr = head_dec;
        if (full) begin
          st = cdb_pkg::ST_FULL;
        end else begin
          mem_we = 1'b1;
          head_d = head_dec;
          cnt_d  = cnt_q + CW'(1);
        end
      end
      cdb_pkg::REQ_POP_BACK: begin
        if (empty) begin
          st = cdb_pkg::ST_EMPTY;
        end else begin
          mem_re = 1'b1;
          cnt_d  = cnt_q - CW'(1);
        end
      end
      cdb_pkg::REQ_POP_FRONT: begin
        mem_addr = head_q;
        if (empty) begin
          st = cdb_pkg::ST_EMPTY;
        end else begin
          mem_re = 1'b1;
          head_d = head_inc;
          cnt_d  = cnt_q - CW'(1);
        end
      end
      cdb_pkg::REQ_READ: begin
        if (!in_range) begin
          st = cdb_pkg::ST_RANGE;
        end else begin
          mem_re = 1'b1;
        end
      end
      cdb_pkg::REQ_WRITE: begin
        if (!in_range) begin
          st = cdb_pkg::ST_RANGE;
        end else begin
          mem_we = 1'b1;
        end
      end
      cdb_pkg::REQ_CLEAR: begin
        head_d = '0;
        cnt_d  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept && mem_we) begin
      mem[mem_addr] <= in_item_i.write_value[DW-1:0];
    end
    if (accept && mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        head_q <= head_d;
        cnt_q  <= cnt_d;
        pend_q <= 1'b1;
      end else if (out_load) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_rd_q  <= mem_re;
      pend_st_q  <= st;
      pend_cnt_q <= cnt_d;
    end
    if (out_load) begin
      out_q.read_value <= pend_rd_q ? cdb_pkg::ValueW'(rdata_q) : '0;
      out_q.status     <= pend_st_q;
      out_q.fill_count <= cdb_pkg::FillW'(pend_cnt_q);
      out_q.is_empty   <= pend_cnt_q == '0;
      out_q.is_full    <= pend_cnt_q == CW'(CAPACITY);
    end
  end

  assign in_ready_o  = !pend_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `CDB_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CW'(CAPACITY), "count over capacity")
  `CDB_ASSERT_NEVER(a_head_bound, clk_i, rst_ni, head_q > AW'(CAPACITY - 1), "head out of range")
  `CDB_ASSERT(a_accept_pend, clk_i, rst_ni, accept |=> pend_q && !in_ready_o, "no interlock")
  `CDB_ASSERT(a_clear, clk_i, rst_ni, accept && (in_item_i.req_type == cdb_pkg::REQ_CLEAR) |=> (head_q == '0) && (cnt_q == '0), "clear failed")
  `CDB_ASSERT(a_empty_st, clk_i, rst_ni, out_valid_o && (out_item_o.status == cdb_pkg::ST_EMPTY) |-> out_item_o.is_empty, "empty status with data")

endmodule

>>> test/cdb_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// Deque scoreboard
// Tracks the ring contents, head and fill level from accepted requests,
// predicts each response and compares the DUT responses against it in order.
// ----------------------------------------------------------------------------
package cdb_scoreboard_pkg;

  localparam int unsigned Depth = 256;
  localparam logic [cdb_pkg::ReqTypeW-1:0] REQ_UNUSED = 3'd7;

  class deque_scoreboard;
    logic [cdb_pkg::ValueW-1:0] ring[Depth];
    logic [cdb_pkg::IndexW-1:0] head;
    logic [cdb_pkg::FillW-1:0]  fill;
    cdb_pkg::rsp_t              awaited_rsp[$];
    int unsigned                errors;

    function new();
      head   = '0;
      fill   = '0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return awaited_rsp.size();
    endfunction

    function void note_request(cdb_pkg::req_t it);
      cdb_pkg::rsp_t              rsp;
      logic [cdb_pkg::IndexW-1:0] slot;
      rsp            = '0;
      rsp.status     = cdb_pkg::ST_OK;
      rsp.read_value = '0;
      case (it.req_type)
        cdb_pkg::REQ_PUSH_BACK: begin
          if (fill == Depth) begin
            rsp.status = cdb_pkg::ST_FULL;
          end else begin
            slot       = head + fill[cdb_pkg::IndexW-1:0];
            ring[slot] = it.write_value;
            fill       = fill + 1'b1;
          end
        end
        cdb_pkg::REQ_PUSH_FRONT: begin
          if (fill == Depth) begin
            rsp.status = cdb_pkg::ST_FULL;
          end else begin
            head       = head - 1'b1;
            ring[head] = it.write_value;
            fill       = fill + 1'b1;
          end
        end
        cdb_pkg::REQ_POP_BACK: begin
          if (fill == 0) begin
            rsp.status = cdb_pkg::ST_EMPTY;
          end else begin
            slot           = head + fill[cdb_pkg::IndexW-1:0] - 1'b1;
            rsp.read_value = ring[slot];
            fill           = fill - 1'b1;
          end
        end
        cdb_pkg::REQ_POP_FRONT: begin
          if (fill == 0) begin
            rsp.status = cdb_pkg::ST_EMPTY;
          end else begin
            rsp.read_value = ring[head];
            head           = head + 1'b1;
            fill           = fill - 1'b1;
          end
        end
        cdb_pkg::REQ_READ: begin
          if (cdb_pkg::FillW'(it.elem_index) >= fill) begin
            rsp.status = cdb_pkg::ST_RANGE;
          end else begin
            slot           = head + it.elem_index;
            rsp.read_value = ring[slot];
          end
        end
        cdb_pkg::REQ_WRITE: begin
          if (cdb_pkg::FillW'(it.elem_index) >= fill) begin
            rsp.status = cdb_pkg::ST_RANGE;
          end else begin
            slot       = head + it.elem_index;
            ring[slot] = it.write_value;
          end
        end
        cdb_pkg::REQ_CLEAR: begin
          head = '0;
          fill = '0;
        end
        default: begin
        end
      endcase
      rsp.fill_count = fill;
      rsp.is_empty   = (fill == 0);
      rsp.is_full    = (fill == Depth);
      awaited_rsp    = {awaited_rsp, rsp};
    endfunction

    function void check_response(cdb_pkg::rsp_t got);
      cdb_pkg::rsp_t exp;
      if (awaited_rsp.size() == 0) begin
        $display("%0t: response with no request pending, got %h", $time, got);
        errors++;
        return;
      end
      exp = awaited_rsp[0];
      awaited_rsp.delete(0);
      if (got.read_value !== exp.read_value) begin
        $display("%0t: read_value expected %h got %h", $time, exp.read_value,
                 got.read_value);
        errors++;
      end
      if (got.status !== exp.status) begin
        $display("%0t: status expected %0d got %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.fill_count !== exp.fill_count) begin
        $display("%0t: fill_count expected %0d got %0d", $time, exp.fill_count,
                 got.fill_count);
        errors++;
      end
      if (got.is_empty !== exp.is_empty) begin
        $display("%0t: is_empty expected %b got %b", $time, exp.is_empty, got.is_empty);
        errors++;
      end
      if (got.is_full !== exp.is_full) begin
        $display("%0t: is_full expected %b got %b", $time, exp.is_full, got.is_full);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// Circular deque buffer testbench
// Directed corner cases, a fill to capacity, churn near full and mixed
// random traffic, with random gaps and stalls on both channels and one long
// output stall that backs up the request side.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    MIX_FILL,
    MIX_NEAR_FULL,
    MIX_ANY
  } mix_e;

  localparam int unsigned StallCycles = 300;
  localparam int unsigned StallAfter  = 120;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  cdb_pkg::req_t  in_item_i;
  logic           out_valid_o;
  logic           out_ready_i;
  cdb_pkg::rsp_t  out_item_o;

  cdb_scoreboard_pkg::deque_scoreboard sb;
  int unsigned                         n_sent;
  bit                                  send_quiet;

  always #6 clk_i = ~clk_i;

  circular_deque_buffer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  function automatic logic [cdb_pkg::ValueW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [cdb_pkg::IndexW-1:0] pick_index();
    int unsigned top;
    if ($urandom_range(0, 9) < 7) begin
      top = (sb.fill > 255) ? 255 : sb.fill;
      return cdb_pkg::IndexW'($urandom_range(0, top));
    end
    return cdb_pkg::IndexW'($urandom_range(0, 255));
  endfunction

  function automatic cdb_pkg::req_t pick_req(mix_e mix);
    cdb_pkg::req_t it;
    int unsigned   r;
    r              = $urandom_range(0, 99);
    it.elem_index  = pick_index();
    it.write_value = pick_value();
    case (mix)
      MIX_FILL: begin
        if (r < 45)      it.req_type = cdb_pkg::REQ_PUSH_BACK;
        else if (r < 90) it.req_type = cdb_pkg::REQ_PUSH_FRONT;
        else if (r < 94) it.req_type = cdb_pkg::REQ_READ;
        else if (r < 98) it.req_type = cdb_pkg::REQ_WRITE;
        else if (r < 99) it.req_type = cdb_pkg::REQ_POP_FRONT;
        else             it.req_type = cdb_pkg::REQ_POP_BACK;
      end
      MIX_NEAR_FULL: begin
        if (r < 25)      it.req_type = cdb_pkg::REQ_PUSH_BACK;
        else if (r < 50) it.req_type = cdb_pkg::REQ_PUSH_FRONT;
        else if (r < 65) it.req_type = cdb_pkg::REQ_POP_BACK;
        else if (r < 80) it.req_type = cdb_pkg::REQ_POP_FRONT;
        else if (r < 88) it.req_type = cdb_pkg::REQ_READ;
        else if (r < 97) it.req_type = cdb_pkg::REQ_WRITE;
        else             it.req_type = cdb_scoreboard_pkg::REQ_UNUSED;
      end
      default: begin
        it.req_type = cdb_pkg::ReqTypeW'($urandom_range(0, 7));
        if (it.req_type == cdb_pkg::REQ_CLEAR && $urandom_range(0, 2) != 0) begin
          it.req_type = cdb_pkg::REQ_PUSH_BACK;
        end
      end
    endcase
    return it;
  endfunction

  task automatic send_req(input cdb_pkg::req_t it);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(it);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_op(input logic [cdb_pkg::ReqTypeW-1:0] op,
                         input logic [cdb_pkg::IndexW-1:0] idx,
                         input logic [cdb_pkg::ValueW-1:0] val);
    cdb_pkg::req_t it;
    it.req_type    = op;
    it.elem_index  = idx;
    it.write_value = val;
    send_req(it);
  endtask

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned n_rsp;
    bit          rcv_quiet;
    int unsigned wait_cycles;
    out_ready_i = 1'b0;
    n_rsp       = 0;
    rcv_quiet   = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) rcv_quiet = !rcv_quiet;
      wait_cycles = rcv_quiet ? 0 : $urandom_range(0, 11);
      if (n_rsp == StallAfter) wait_cycles = StallCycles;
      if (wait_cycles > 0) begin
        out_ready_i = 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_response(out_item_o);
      n_rsp++;
      @(negedge clk_i);
    end
  end

  initial begin
    int unsigned k;
    sb         = new();
    n_sent     = 0;
    send_quiet = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_op(cdb_pkg::REQ_POP_BACK, 8'd0, 32'h0);
    send_op(cdb_pkg::REQ_POP_FRONT, 8'd0, 32'h0);
    send_op(cdb_pkg::REQ_READ, 8'd0, 32'h0);
    send_op(cdb_pkg::REQ_WRITE, 8'd255, 32'hFFFF_FFFF);
    send_op(cdb_scoreboard_pkg::REQ_UNUSED, 8'd255, 32'hFFFF_FFFF);
    send_op(cdb_pkg::REQ_PUSH_BACK, 8'd0, 32'h0);
    send_op(cdb_pkg::REQ_PUSH_FRONT, 8'd255, 32'hFFFF_FFFF);
    send_op(cdb_pkg::REQ_PUSH_BACK, 8'd0, 32'hA5A5_A5A5);
    send_op(cdb_pkg::REQ_READ, 8'd0, 32'h0);
    send_op(cdb_pkg::REQ_READ, 8'd2, 32'h0);
    send_op(cdb_pkg::REQ_READ, 8'd3, 32'h0);
    send_op(cdb_pkg::REQ_WRITE, 8'd1, 32'h1234_5678);
    send_op(cdb_pkg::REQ_READ, 8'd1, 32'h0);
    send_op(cdb_pkg::REQ_POP_FRONT, 8'd0, 32'h0);
    send_op(cdb_pkg::REQ_POP_BACK, 8'd0, 32'h0);
    send_op(cdb_scoreboard_pkg::REQ_UNUSED, 8'd0, 32'h0);
    send_op(cdb_pkg::REQ_CLEAR, 8'd0, 32'h0);
    send_op(cdb_pkg::REQ_READ, 8'd0, 32'h0);
    send_op(cdb_pkg::REQ_POP_FRONT, 8'd0, 32'h0);
    send_op(cdb_pkg::REQ_PUSH_FRONT, 8'd0, 32'hDEAD_BEEF);
    send_op(cdb_pkg::REQ_READ, 8'd255, 32'h0);
    send_op(cdb_pkg::REQ_POP_BACK, 8'd0, 32'h0);

    while (sb.fill < cdb_scoreboard_pkg::Depth) send_req(pick_req(MIX_FILL));
    for (k = 0; k < 60; k++) send_req(pick_req(MIX_NEAR_FULL));
    send_op(cdb_pkg::REQ_CLEAR, 8'd0, 32'h0);
    while (n_sent < 560) send_req(pick_req(MIX_ANY));
    in_valid_i = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/cdb_pkg.sv
rtl/core/circular_deque_buffer.sv
test/cdb_scoreboard_pkg.sv
test/tb_top.sv
